// ----- rtl/fds_pkg.sv -----
// Shared types and constants of the fingerprint dictionary selector.
// No dependencies; every rtl file but fds_cmd_fifo refers to it by scoped names.
`default_nettype none

package fds_pkg;

  localparam int HASH_W     = 32;
  localparam int COUNT_W    = 17;
  localparam int SCORE_W    = 16;
  localparam int BYTE_W     = 8;
  localparam int SLOT_IN_W  = 4;
  localparam int MAX_LIVE   = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int SIU_W      = 5;
  localparam int PLEN_W     = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;
  localparam logic [SCORE_W-1:0] SCORE_MAX = 16'hFFFF;

  localparam logic [SIU_W-1:0]  SLOTS_IN_USE_RESET = 5'd4;
  localparam logic [PLEN_W-1:0] PROBE_LENGTH_RESET = 16'd16384;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_LENGTH = 8'd1;

  // Classification of one request, passed from front to back.
  typedef struct packed {
    logic train;  // training byte (else probe byte)
    logic clear;  // segment start: clear slot table or scores
    logic mark;   // set table bit (training) or score at index (probe)
    logic emit;   // deliver a selection result
    logic skip;   // result is slot 0 with 0 hits
  } cmd_flags_t;

endpackage

`default_nettype wire

// ----- rtl/fingerprint_dictionary_selector_core.sv -----
// Top level of the fingerprint dictionary selector: front, command queue, back.
// Depends on fds_pkg, fds_front, fds_cmd_fifo and fds_back.
//
//   channel  handshake              payload
//   in       in_valid / in_stall    in_operation, in_slot, in_data_byte, in_first, in_last
//   out      out_valid / out_stall  out_chosen_slot, out_hit_count
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Bytes enter at one per cycle while in_stall is low into a four-deep queue;
// the back part retires one command per cycle while it is in its run state.
// A training byte that starts a segment sweeps the slot's whole memory. A last
// probe byte holds the back part for the settle, scan and load steps, for the load step
// alone when selection is skipped; a stalled result holds it in the load step and
// the queue then fills to in_stall. After reset a clearing pass over the whole memory
// runs with in_stall high; cfg writes are taken throughout.
`default_nettype none

module fingerprint_dictionary_selector_core #(
  parameter int SLOTS      = 16,
  parameter int INDEX_BITS = 12,
  parameter int WINDOW     = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_operation,
  input  wire logic [fds_pkg::SLOT_IN_W-1:0]   in_slot,
  input  wire logic [fds_pkg::BYTE_W-1:0]      in_data_byte,
  input  wire logic                            in_first,
  input  wire logic                            in_last,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [fds_pkg::SLOT_IN_W-1:0]        out_chosen_slot,
  output logic [fds_pkg::SCORE_W-1:0]          out_hit_count,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [fds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fds_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int LIVE   = (SLOTS < fds_pkg::MAX_LIVE) ? SLOTS : fds_pkg::MAX_LIVE;
  localparam int SLOT_W = $clog2(LIVE);
  localparam int FL_W   = $bits(fds_pkg::cmd_flags_t);
  localparam int CMD_W  = FL_W + SLOT_W + INDEX_BITS + LIVE + SLOT_W;

  fds_pkg::cmd_flags_t    f_flags;
  logic [SLOT_W-1:0]      f_slot;
  logic [INDEX_BITS-1:0]  f_idx;
  logic [LIVE-1:0]        f_act;
  logic [SLOT_W-1:0]      f_last;
  logic                   f_push;

  fds_pkg::cmd_flags_t    b_flags;
  logic [SLOT_W-1:0]      b_slot;
  logic [INDEX_BITS-1:0]  b_idx;
  logic [LIVE-1:0]        b_act;
  logic [SLOT_W-1:0]      b_last;
  logic                   b_pop;

  logic [CMD_W-1:0]       q_in;
  logic [CMD_W-1:0]       q_out;
  logic                   q_full;
  logic                   q_empty;
  logic                   init_busy;

  assign q_in = {f_flags, f_slot, f_idx, f_act, f_last};
  assign {b_flags, b_slot, b_idx, b_act, b_last} = q_out;

  fds_front #(
    .SLOTS      (SLOTS),
    .INDEX_BITS (INDEX_BITS),
    .WINDOW     (WINDOW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_slot      (in_slot),
    .in_data_byte (in_data_byte),
    .in_first     (in_first),
    .in_last      (in_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_full       (q_full),
    .back_init    (init_busy),
    .push         (f_push),
    .cmd_flags    (f_flags),
    .cmd_slot     (f_slot),
    .cmd_idx      (f_idx),
    .cmd_act      (f_act),
    .cmd_last     (f_last)
  );

  fds_cmd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (fds_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (b_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  fds_back #(
    .SLOTS      (SLOTS),
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .pop             (b_pop),
    .cmd_flags       (b_flags),
    .cmd_slot        (b_slot),
    .cmd_idx         (b_idx),
    .cmd_act         (b_act),
    .cmd_last        (b_last),
    .init_busy       (init_busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_chosen_slot (out_chosen_slot),
    .out_hit_count   (out_hit_count)
  );

endmodule

`default_nettype wire

// ----- rtl/fds_cmd_fifo.sv -----
// Short command queue between the front and back parts of the selector.
// Depends on nothing but its parameters.
`default_nettype none

module fds_cmd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  logic do_push;
  logic do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fds_front.sv -----
// Front part: configuration registers, rolling hash and byte count,
// classification of each accepted byte into a queued command. Uses fds_pkg.
`default_nettype none

module fds_front #(
  parameter int SLOTS      = 16,
  parameter int INDEX_BITS = 12,
  parameter int WINDOW     = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_operation,
  input  wire logic [fds_pkg::SLOT_IN_W-1:0]    in_slot,
  input  wire logic [fds_pkg::BYTE_W-1:0]       in_data_byte,
  input  wire logic                             in_first,
  input  wire logic                             in_last,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [fds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fds_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             q_full,
  input  wire logic                             back_init,
  output logic                                  push,
  output fds_pkg::cmd_flags_t                   cmd_flags,
  output logic [$clog2((SLOTS < 16) ? SLOTS : 16)-1:0] cmd_slot,
  output logic [INDEX_BITS-1:0]                 cmd_idx,
  output logic [((SLOTS < 16) ? SLOTS : 16)-1:0] cmd_act,
  output logic [$clog2((SLOTS < 16) ? SLOTS : 16)-1:0] cmd_last
);

  localparam int LIVE   = (SLOTS < fds_pkg::MAX_LIVE) ? SLOTS : fds_pkg::MAX_LIVE;
  localparam int SLOT_W = $clog2(LIVE);
  localparam int HW     = fds_pkg::HASH_W;
  localparam int CW     = fds_pkg::COUNT_W;
  localparam int SW     = fds_pkg::SIU_W;

  logic [SW-1:0]                slots_in_use_r;
  logic [fds_pkg::PLEN_W-1:0]   probe_length_r;
  logic [HW-1:0]                hash_r;
  logic [CW-1:0]                count_r;

  logic          accept;
  logic          slot_ok;
  logic          absorb;
  logic          take;
  logic [HW-1:0] h0;
  logic [HW-1:0] h1;
  logic [HW-1:0] hash_nxt;
  logic [CW-1:0] c0;
  logic [CW-1:0] c1;
  logic [CW-1:0] count_nxt;
  logic [SW-1:0] n_act;
  logic          mark;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full || back_init;
  assign accept    = in_valid && !in_stall;

  // Slot indexes at or above the live slot count are never trained.
  assign slot_ok = (SW'(in_slot) < SW'(LIVE));
  assign n_act   = (slots_in_use_r > SW'(LIVE)) ? SW'(LIVE) : slots_in_use_r;

  always_comb begin
    h0 = in_first ? '0 : hash_r;
    c0 = in_first ? '0 : count_r;
    h1 = {h0[HW-2:0], h0[HW-1]} ^ HW'(in_data_byte);
    c1 = (c0 == fds_pkg::COUNT_MAX) ? c0 : c0 + 1'b1;
    absorb = !in_operation || (c0 < CW'(probe_length_r));
    hash_nxt  = absorb ? h1 : h0;
    count_nxt = absorb ? c1 : c0;
    mark = absorb && (count_nxt >= CW'(WINDOW));
    take = in_operation || slot_ok;
  end

  always_comb begin
    cmd_flags.train = !in_operation;
    cmd_flags.clear = in_first;
    cmd_flags.mark  = mark;
    cmd_flags.emit  = in_operation && in_last;
    cmd_flags.skip  = (n_act <= SW'(1)) || (count_nxt < CW'(WINDOW));
    cmd_slot = in_slot[SLOT_W-1:0];
    cmd_idx  = hash_nxt[INDEX_BITS-1:0];
    cmd_last = SLOT_W'(n_act - 1'b1);
    for (int s = 0; s < LIVE; s++) begin
      cmd_act[s] = (SW'(s) < n_act);
    end
    if (in_operation) begin
      push = accept && (in_first || mark || in_last);
    end else begin
      push = accept && slot_ok && (in_first || mark);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_in_use_r <= fds_pkg::SLOTS_IN_USE_RESET;
      probe_length_r <= fds_pkg::PROBE_LENGTH_RESET;
      hash_r         <= '0;
      count_r        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == fds_pkg::CFG_SLOTS_IN_USE) begin
          slots_in_use_r <= cfg_data[SW-1:0];
        end else if (cfg_index == fds_pkg::CFG_PROBE_LENGTH) begin
          probe_length_r <= cfg_data;
        end
      end
      // Drop training bytes for slots that do not exist.
      if (accept && take) begin
        hash_r  <= hash_nxt;
        count_r <= count_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fds_back.sv -----
// Back part: per-slot presence memories, slot scores, clearing sweeps,
// best-slot scan and the result register. Uses fds_pkg.
`default_nettype none

module fds_back #(
  parameter int SLOTS      = 16,
  parameter int INDEX_BITS = 12
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             q_empty,
  output logic                                  pop,
  input  wire fds_pkg::cmd_flags_t              cmd_flags,
  input  wire logic [$clog2((SLOTS < 16) ? SLOTS : 16)-1:0] cmd_slot,
  input  wire logic [INDEX_BITS-1:0]            cmd_idx,
  input  wire logic [((SLOTS < 16) ? SLOTS : 16)-1:0] cmd_act,
  input  wire logic [$clog2((SLOTS < 16) ? SLOTS : 16)-1:0] cmd_last,
  output logic                                  init_busy,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [fds_pkg::SLOT_IN_W-1:0]         out_chosen_slot,
  output logic [fds_pkg::SCORE_W-1:0]           out_hit_count
);

  localparam int LIVE   = (SLOTS < fds_pkg::MAX_LIVE) ? SLOTS : fds_pkg::MAX_LIVE;
  localparam int SLOT_W = $clog2(LIVE);
  localparam int TABLE  = 1 << INDEX_BITS;
  localparam int SCW    = fds_pkg::SCORE_W;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_RUN,
    S_SETTLE,
    S_SCAN,
    S_PUSH
  } state_t;

  state_t                 state_r;
  logic                   init_r;
  logic [INDEX_BITS-1:0]  sweep_addr_r;
  logic [LIVE-1:0]        sweep_mask_r;
  logic                   sweep_set_r;
  logic [INDEX_BITS-1:0]  sweep_idx_r;
  logic                   pend_r;
  logic [LIVE-1:0]        pend_act_r;
  logic [SCW-1:0]         scores_r [LIVE];
  logic [SCW-1:0]         scores_nxt [LIVE];
  logic [SLOT_W-1:0]      scan_r;
  logic [SLOT_W-1:0]      last_r;
  logic [SLOT_W-1:0]      best_r;
  logic [SCW-1:0]         best_score_r;
  logic                   out_valid_r;
  logic [SLOT_W-1:0]      out_slot_r;
  logic [SCW-1:0]         out_hit_r;

  logic [INDEX_BITS-1:0]  mem_addr;
  logic [LIVE-1:0]        mem_we;
  logic                   mem_wd;
  logic [LIVE-1:0]        rd_q;
  logic                   probe_pop;

  assign pop             = (state_r == S_RUN) && !q_empty;
  assign probe_pop       = pop && !cmd_flags.train;
  assign init_busy       = init_r;
  assign out_valid       = out_valid_r;
  assign out_chosen_slot = fds_pkg::SLOT_IN_W'(out_slot_r);
  assign out_hit_count   = out_hit_r;

  always_comb begin
    if (state_r == S_SWEEP) begin
      mem_addr = sweep_addr_r;
      mem_we   = sweep_mask_r;
      mem_wd   = sweep_set_r && (sweep_addr_r == sweep_idx_r);
    end else begin
      mem_addr = cmd_idx;
      mem_wd   = 1'b1;
      for (int s = 0; s < LIVE; s++) begin
        mem_we[s] = pop && cmd_flags.train && !cmd_flags.clear && cmd_flags.mark &&
                    (cmd_slot == SLOT_W'(s));
      end
    end
  end

  // One bit-wide memory per slot, all at the same address.
  for (genvar g = 0; g < LIVE; g++) begin : g_slot_mem
    logic mem [TABLE];
    always_ff @(posedge clk) begin
      if (mem_we[g]) begin
        mem[mem_addr] <= mem_wd;
      end
      rd_q[g] <= mem[mem_addr];
    end
  end

  // Increments of the previous probe land first; a new probe segment then clears.
  always_comb begin
    for (int s = 0; s < LIVE; s++) begin
      scores_nxt[s] = scores_r[s];
      if (pend_r && pend_act_r[s] && rd_q[s] && (scores_r[s] != fds_pkg::SCORE_MAX)) begin
        scores_nxt[s] = scores_r[s] + 1'b1;
      end
      if (probe_pop && cmd_flags.clear) begin
        scores_nxt[s] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < LIVE; s++) begin
        scores_r[s] <= '0;
      end
      pend_r <= 1'b0;
    end else begin
      for (int s = 0; s < LIVE; s++) begin
        scores_r[s] <= scores_nxt[s];
      end
      pend_r <= probe_pop && cmd_flags.mark;
    end
  end

  always_ff @(posedge clk) begin
    pend_act_r <= cmd_act;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      init_r       <= 1'b1;
      sweep_addr_r <= '0;
      sweep_mask_r <= '1;
      sweep_set_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // Drop an accepted result unless the load step replaces it this cycle.
      if (out_valid_r && !out_stall && (state_r != S_PUSH)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_SWEEP: begin
          sweep_addr_r <= sweep_addr_r + 1'b1;
          if (sweep_addr_r == '1) begin
            init_r  <= 1'b0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (pop) begin
            if (cmd_flags.train) begin
              if (cmd_flags.clear) begin
                sweep_addr_r <= '0;
                sweep_mask_r <= LIVE'(1) << cmd_slot;
                sweep_set_r  <= cmd_flags.mark;
                sweep_idx_r  <= cmd_idx;
                state_r      <= S_SWEEP;
              end
            end else if (cmd_flags.emit) begin
              last_r       <= cmd_last;
              scan_r       <= '0;
              best_r       <= '0;
              best_score_r <= '0;
              state_r      <= cmd_flags.skip ? S_PUSH : S_SETTLE;
            end
          end
        end
        S_SETTLE: begin
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (scores_r[scan_r] > best_score_r) begin
            best_r       <= scan_r;
            best_score_r <= scores_r[scan_r];
          end
          scan_r <= scan_r + 1'b1;
          if (scan_r == last_r) begin
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_slot_r  <= best_r;
            out_hit_r   <= best_score_r;
            state_r     <= S_RUN;
          end
        end
        default: begin
          state_r <= S_RUN;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb_fingerprint_dictionary_selector_core.sv -----
// Testbench of fingerprint_dictionary_selector_core: directed, random and zero-hash byte
// streams, each selection checked against an in-bench model of hash, tables and scores.
// Depends on fds_pkg and the rtl top level; needs no files or arguments.
module tb_fingerprint_dictionary_selector_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS        = 16;
  localparam int INDEX_BITS   = 12;
  localparam int WINDOW       = 4;
  localparam int TABLE_BITS   = 1 << INDEX_BITS;
  localparam int CLK_HALF     = 4;
  localparam int DRAIN_CYCLES = (fds_pkg::QUEUE_DEPTH + 2) * (TABLE_BITS + 64);
  localparam int MAX_TEXT     = 48;
  localparam longint TIMEOUT_NS = 64'd400_000_000;

  localparam int SLOT_IN_W  = fds_pkg::SLOT_IN_W;
  localparam int SCORE_W    = fds_pkg::SCORE_W;
  localparam int BYTE_W     = fds_pkg::BYTE_W;
  localparam int HASH_W     = fds_pkg::HASH_W;
  localparam int COUNT_W    = fds_pkg::COUNT_W;
  localparam int SIU_W      = fds_pkg::SIU_W;
  localparam int PLEN_W     = fds_pkg::PLEN_W;
  localparam int CFG_IDX_W  = fds_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = fds_pkg::CFG_DATA_W;

  typedef enum logic {OP_TRAIN = 1'b0, OP_PROBE = 1'b1} op_t;

  typedef struct packed {
    logic [SLOT_IN_W-1:0] slot;
    logic [SCORE_W-1:0]   hits;
  } selection_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_operation = 1'b0;
  logic [SLOT_IN_W-1:0]  in_slot = '0;
  logic [BYTE_W-1:0]     in_data_byte = '0;
  logic                  in_first = 1'b0;
  logic                  in_last = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [SLOT_IN_W-1:0]  out_chosen_slot;
  logic [SCORE_W-1:0]    out_hit_count;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // model state
  logic [TABLE_BITS-1:0] presence [SLOTS];
  logic [SCORE_W-1:0]    score [SLOTS];
  logic [HASH_W-1:0]     hash_acc;
  logic [COUNT_W-1:0]    byte_cnt;
  logic [SIU_W-1:0]      slots_cfg;
  logic [PLEN_W-1:0]     probe_len_cfg;
  selection_t            expected_selections [$];

  // last training segment per slot, replayed as probe chunks
  logic [BYTE_W-1:0]     seg_text [SLOTS][MAX_TEXT];
  int unsigned           seg_len [SLOTS];
  logic [BYTE_W-1:0]     text_buf [64];

  int unsigned           gap_pct;
  int unsigned           stall_pct;
  int unsigned           err_count = 0;
  selection_t            head_sel;

  fingerprint_dictionary_selector_core #(
    .SLOTS(SLOTS),
    .INDEX_BITS(INDEX_BITS),
    .WINDOW(WINDOW)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_slot(in_slot),
    .in_data_byte(in_data_byte),
    .in_first(in_first),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_chosen_slot(out_chosen_slot),
    .out_hit_count(out_hit_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_selections.size() == 0) begin
        report_mismatch($sformatf("unexpected selection slot %0d hits %0d",
                                  out_chosen_slot, out_hit_count));
      end else begin
        head_sel = expected_selections.pop_front();
        if (out_chosen_slot !== head_sel.slot)
          report_mismatch($sformatf("chosen_slot %0d, want %0d", out_chosen_slot,
                                    head_sel.slot));
        if (out_hit_count !== head_sel.hits)
          report_mismatch($sformatf("hit_count %0d, want %0d", out_hit_count,
                                    head_sel.hits));
      end
    end
  end

  task automatic fold_byte(input logic [BYTE_W-1:0] b);
    hash_acc = {hash_acc[HASH_W-2:0], hash_acc[HASH_W-1]} ^ {{(HASH_W-BYTE_W){1'b0}}, b};
    if (byte_cnt != fds_pkg::COUNT_MAX) byte_cnt++;
  endtask

  task automatic predict_selection(input op_t op, input logic [SLOT_IN_W-1:0] slot,
                                   input logic [BYTE_W-1:0] data, input logic first,
                                   input logic last);
    int unsigned live;
    logic [INDEX_BITS-1:0] idx;
    selection_t sel;
    if (op == OP_TRAIN) begin
      if (slot >= SLOTS) return;
      if (first) begin
        hash_acc = '0;
        byte_cnt = '0;
        presence[slot] = '0;
      end
      fold_byte(data);
      if (byte_cnt >= WINDOW) presence[slot][hash_acc[INDEX_BITS-1:0]] = 1'b1;
      return;
    end
    if (first) begin
      hash_acc = '0;
      byte_cnt = '0;
      for (int s = 0; s < SLOTS; s++) score[s] = '0;
    end
    live = slots_cfg;
    if (live > SLOTS) live = SLOTS;
    if (live > fds_pkg::MAX_LIVE) live = fds_pkg::MAX_LIVE;
    // bytes past the probe length leave hash, count and scores alone
    if (byte_cnt < probe_len_cfg) begin
      fold_byte(data);
      if (byte_cnt >= WINDOW) begin
        idx = hash_acc[INDEX_BITS-1:0];
        for (int s = 0; s < live; s++)
          if (presence[s][idx] && score[s] != fds_pkg::SCORE_MAX) score[s]++;
      end
    end
    if (!last) return;
    sel = '0;
    if (live > 1 && byte_cnt >= WINDOW) begin
      for (int s = 0; s < live; s++) begin
        if (score[s] > sel.hits) begin
          sel.hits = score[s];
          sel.slot = SLOT_IN_W'(s);
        end
      end
    end
    expected_selections.push_back(sel);
  endtask

  task automatic send_byte(input op_t op, input logic [SLOT_IN_W-1:0] slot,
                           input logic [BYTE_W-1:0] data, input logic first,
                           input logic last);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_slot      <= slot;
    in_data_byte <= data;
    in_first     <= first;
    in_last      <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_selection(op, slot, data, first, last);
  endtask

  task automatic send_text(input op_t op, input logic [SLOT_IN_W-1:0] slot,
                           input int unsigned len, input logic first_on,
                           input logic last_on);
    for (int i = 0; i < len; i++)
      send_byte(op, slot, text_buf[i], first_on && i == 0, last_on && i == len - 1);
    if (op == OP_TRAIN && first_on) begin
      seg_len[slot] = len;
      for (int i = 0; i < len; i++) seg_text[slot][i] = text_buf[i];
    end
  endtask

  task automatic load_segment(input int unsigned src);
    for (int i = 0; i < seg_len[src]; i++) text_buf[i] = seg_text[src][i];
  endtask

  // hold until every selection is in, then let every queued table sweep drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_selections.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      fds_pkg::CFG_SLOTS_IN_USE: slots_cfg = data[SIU_W-1:0];
      fds_pkg::CFG_PROBE_LENGTH: probe_len_cfg = data[PLEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [SIU_W-1:0] siu, input logic [PLEN_W-1:0] plen);
    wait_idle();
    cfg_write(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
    cfg_write(fds_pkg::CFG_SLOTS_IN_USE, {(CFG_DATA_W-SIU_W)'($urandom), siu});
    cfg_write(fds_pkg::CFG_PROBE_LENGTH, plen);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    // a single byte is too short to select
    send_byte(OP_PROBE, 4'h0, 8'hFF, 1'b1, 1'b1);
    text_buf[0] = 8'h00;
    text_buf[1] = 8'hFF;
    text_buf[2] = 8'h5A;
    text_buf[3] = 8'hA5;
    text_buf[4] = 8'h3C;
    send_text(OP_TRAIN, 4'h0, 5, 1'b1, 1'b1);
    send_text(OP_PROBE, 4'hF, 5, 1'b1, 1'b1);
    for (int i = 0; i < 6; i++) text_buf[i] = 8'hC3;
    send_text(OP_PROBE, 4'h0, 6, 1'b1, 1'b1);
  endtask

  task automatic test_config_extremes();
    set_config(5'd31, 16'hFFFF);
    load_segment(0);
    send_text(OP_PROBE, 4'h0, 5, 1'b1, 1'b1);
    set_config(5'd0, 16'h0000);
    send_text(OP_PROBE, 4'h0, 5, 1'b1, 1'b1);
    set_config(5'd1, 16'd16384);
    send_text(OP_PROBE, 4'h0, 5, 1'b1, 1'b1);
    // the fifth byte lies past the probe length but still carries last
    set_config(5'd2, 16'd4);
    send_text(OP_PROBE, 4'h0, 5, 1'b1, 1'b1);
  endtask

  task automatic test_random_streams(input int unsigned n_items);
    int unsigned sent, kind, len, src, span;
    for (int half = 0; half < 2; half++) begin
      if ($urandom_range(9) == 0)
        set_config(SIU_W'($urandom_range(31)), PLEN_W'($urandom));
      else if ($urandom_range(3) == 0)
        set_config(SIU_W'($urandom_range(2, 16)), PLEN_W'($urandom_range(1, 24)));
      else
        set_config(SIU_W'($urandom_range(2, 16)), PLEN_W'($urandom));
      sent = 0;
      while (sent < n_items / 2) begin
        span = (slots_cfg == 0) ? 1 : ((slots_cfg > SLOTS) ? SLOTS : slots_cfg);
        src = ($urandom_range(4) == 0) ? $urandom_range(SLOTS - 1) : $urandom_range(span - 1);
        kind = $urandom_range(99);
        if (kind < 25) begin
          len = $urandom_range(1, MAX_TEXT);
          for (int i = 0; i < len; i++) text_buf[i] = BYTE_W'($urandom);
          send_text(OP_TRAIN, SLOT_IN_W'(src), len, 1'b1, $urandom_range(9) != 0);
        end else if (kind < 90) begin
          if (kind < 75 && seg_len[src] != 0) begin
            // replay a trained prefix, lightly mutated, with a random tail
            load_segment(src);
            len = $urandom_range(1, seg_len[src]);
            for (int i = 0; i < len; i++)
              if ($urandom_range(15) == 0) text_buf[i] = BYTE_W'($urandom);
            for (int i = 0; i < $urandom_range(8); i++) text_buf[len++] = BYTE_W'($urandom);
          end else begin
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++) text_buf[i] = BYTE_W'($urandom);
          end
          send_text(OP_PROBE, SLOT_IN_W'($urandom), len, $urandom_range(9) != 0,
                    $urandom_range(9) != 0);
        end else begin
          len = 1;
          send_byte(op_t'($urandom_range(1)), SLOT_IN_W'($urandom), BYTE_W'($urandom),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        sent += len;
      end
    end
  endtask

  // all-zero text keeps the hash at zero, so every byte from the window on hits table bit zero
  task automatic test_shared_state();
    set_config(5'd2, 16'hFFFF);
    for (int i = 0; i < 24; i++) send_byte(OP_TRAIN, 4'h0, 8'h00, i == 0, 1'b0);
    for (int i = 0; i < 20; i++) send_byte(OP_PROBE, 4'h0, 8'h00, i == 0, i == 19);
    // restart the count without clearing scores, then keep probing
    for (int i = 0; i < 4; i++) send_byte(OP_TRAIN, 4'h1, 8'h00, i == 0, 1'b0);
    for (int i = 0; i < 12; i++) send_byte(OP_PROBE, 4'h0, 8'h00, 1'b0, i == 11);
  endtask

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      presence[s] = '0;
      score[s] = '0;
      seg_len[s] = 0;
    end
    hash_acc = '0;
    byte_cnt = '0;
    slots_cfg = fds_pkg::SLOTS_IN_USE_RESET;
    probe_len_cfg = fds_pkg::PROBE_LENGTH_RESET;
    gap_pct = 35;
    stall_pct = 80;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_config_extremes();
    test_random_streams(650);
    gap_pct = 80;
    stall_pct = 35;
    test_random_streams(650);
    gap_pct = 0;
    stall_pct = 0;
    test_random_streams(650);
    test_shared_state();
    wait_idle();
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

endmodule
